### hdl/wgrs_pkg.sv
package wgrs_pkg;

  // field widths
  localparam int KIND_W   = 2;
  localparam int ROW_W    = 5;
  localparam int COL_W    = 4;
  localparam int WEIGHT_W = 17;
  localparam int DRAW_W   = 17;
  localparam int CELL_W   = 24;

  // map size defaults
  localparam int DEF_MAP_ROWS = 32;
  localparam int DEF_MAP_COLS = 16;

  // fixed point constants
  localparam logic [CELL_W-1:0] CELL_MAX    = {CELL_W{1'b1}};
  localparam logic [CELL_W-1:0] FLOOR_RESET = 24'd87;
  localparam logic [DRAW_W-1:0] DRAW_ONE    = 17'd100000;

  // split point for the draw times total product
  localparam int TOTAL_SPLIT = 17;

  // item kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_ADD    = 2'd1,
    KIND_SAMPLE = 2'd2
  } kind_t;

  // controller to datapath commands
  typedef struct packed {
    logic load_item;
    logic sweep_wr;
    logic sweep_fill;
    logic add_rd;
    logic add_wr;
    logic tgt_mul;
    logic scan_start;
    logic scan_rd;
    logic out_load;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic addr_last;
    logic add_ok;
    logic found;
    logic pipe_empty;
    logic out_busy;
  } stat_t;

endpackage

### hdl/wgrs_in_if.sv
interface wgrs_in_if;
  logic                         valid;
  logic                         ready;
  logic [wgrs_pkg::KIND_W-1:0]   kind;
  logic [wgrs_pkg::ROW_W-1:0]    row;
  logic [wgrs_pkg::COL_W-1:0]    column;
  logic [wgrs_pkg::WEIGHT_W-1:0] weight;
  logic [wgrs_pkg::DRAW_W-1:0]   draw;

  modport source (output valid, kind, row, column, weight, draw, input ready);
  modport sink (input valid, kind, row, column, weight, draw, output ready);
endinterface

### hdl/wgrs_out_if.sv
interface wgrs_out_if;
  logic                      valid;
  logic                      ready;
  logic [wgrs_pkg::ROW_W-1:0] pick_row;
  logic [wgrs_pkg::COL_W-1:0] pick_column;

  modport source (output valid, pick_row, pick_column, input ready);
  modport sink (input valid, pick_row, pick_column, output ready);
endinterface

### hdl/wgrs_cfg_if.sv
interface wgrs_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [wgrs_pkg::CELL_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

### hdl/weighted_grid_roulette_sampler.sv
// weighted grid roulette sampler
//
// item_in beat: kind selects clear (set every cell to the floor value), add
// (add weight to cell row/column, saturating) or sample (pick a cell with
// probability proportional to its weight, using draw in 0..100000).
// pick_out beat: pick_row/pick_column, one per sample item only.
// cfg beat: new floor value, always ready; write it only while idle.
// Steps, with N = MAP_ROWS * MAP_COLS cells held in one map RAM:
//   clear  - one RAM write per cycle over all N cells
//   add    - RAM read then write back (skipped when outside the map)
//   sample - the draw*total product as two partial products and a sum,
//            then one cell read per cycle and a three-stage multiply/sum
//            pipeline; the walk stops at the first matching cell
// Items are taken one at a time. The result sits in an output register, so
// the next item is accepted while pick_out is stalled; a further sample then
// waits at its end until the register frees up.
// After reset the map RAM is cleared to zero, one cell per cycle;
// item_in stays not ready meanwhile, cfg is still taken.
module weighted_grid_roulette_sampler #(
  parameter int MAP_ROWS = wgrs_pkg::DEF_MAP_ROWS,
  parameter int MAP_COLS = wgrs_pkg::DEF_MAP_COLS
) (
  input logic        clk,
  input logic        rst,
  wgrs_in_if.sink    item_in,
  wgrs_out_if.source pick_out,
  wgrs_cfg_if.sink   cfg
);
  import wgrs_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg.ready = 1'b1;

  wgrs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item_in.valid),
    .in_kind  (item_in.kind),
    .in_ready (item_in.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  wgrs_dp #(
    .MAP_ROWS (MAP_ROWS),
    .MAP_COLS (MAP_COLS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_wr     (cfg.valid),
    .cfg_data   (cfg.data),
    .in_row     (item_in.row),
    .in_column  (item_in.column),
    .in_weight  (item_in.weight),
    .in_draw    (item_in.draw),
    .out_valid  (pick_out.valid),
    .out_ready  (pick_out.ready),
    .out_row    (pick_out.pick_row),
    .out_column (pick_out.pick_column)
  );

endmodule

### hdl/wgrs_ram.sv
module wgrs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 512,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hdl/wgrs_ctrl.sv
module wgrs_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic [wgrs_pkg::KIND_W-1:0] in_kind,
  output logic                      in_ready,
  input  wgrs_pkg::stat_t            stat,
  output wgrs_pkg::cmd_t             cmd
);
  import wgrs_pkg::*;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_TGT,
    ST_TGT_SUM,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  // commands and next state
  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    unique case (state)
      ST_INIT: begin
        cmd.sweep_wr = 1'b1;
        if (stat.addr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
        if (in_valid) begin
          case (in_kind)
            KIND_CLEAR:  state_next = ST_CLEAR;
            KIND_ADD:    state_next = ST_ADD_RD;
            KIND_SAMPLE: state_next = ST_TGT;
            default:     state_next = ST_IDLE;
          endcase
        end
      end
      ST_CLEAR: begin
        cmd.sweep_wr   = 1'b1;
        cmd.sweep_fill = 1'b1;
        if (stat.addr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_ADD_RD: begin
        cmd.add_rd = stat.add_ok;
        state_next = stat.add_ok ? ST_ADD_WR : ST_IDLE;
      end
      ST_ADD_WR: begin
        cmd.add_wr = 1'b1;
        state_next = ST_IDLE;
      end
      ST_TGT: begin
        cmd.tgt_mul = 1'b1;
        state_next  = ST_TGT_SUM;
      end
      ST_TGT_SUM: begin
        cmd.scan_start = 1'b1;
        state_next     = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan_rd = !stat.found;
        if (stat.found) begin
          state_next = ST_DONE;
        end else if (stat.addr_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (stat.found || stat.pipe_empty) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        cmd.out_load = !stat.out_busy;
        if (!stat.out_busy) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTH
  // a sample result is only loaded once the scan has settled
  a_load_after_scan: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (stat.found || stat.pipe_empty))
    else $error("result loaded before scan settled");

  // an add write always comes in the cycle after its read
  a_add_rmw: assert property (@(posedge clk) disable iff (rst)
    cmd.add_wr |-> $past(cmd.add_rd))
    else $error("add write without preceding read");

  // items are taken only outside any sweep or scan
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd.sweep_wr || cmd.scan_rd) |-> !in_ready)
    else $error("item accepted while busy");
`endif

endmodule

### hdl/wgrs_dp.sv
module wgrs_dp #(
  parameter int MAP_ROWS = wgrs_pkg::DEF_MAP_ROWS,
  parameter int MAP_COLS = wgrs_pkg::DEF_MAP_COLS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  wgrs_pkg::cmd_t               cmd,
  output wgrs_pkg::stat_t              stat,
  input  logic                        cfg_wr,
  input  logic [wgrs_pkg::CELL_W-1:0]   cfg_data,
  input  logic [wgrs_pkg::ROW_W-1:0]    in_row,
  input  logic [wgrs_pkg::COL_W-1:0]    in_column,
  input  logic [wgrs_pkg::WEIGHT_W-1:0] in_weight,
  input  logic [wgrs_pkg::DRAW_W-1:0]   in_draw,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [wgrs_pkg::ROW_W-1:0]    out_row,
  output logic [wgrs_pkg::COL_W-1:0]    out_column
);
  import wgrs_pkg::*;

  localparam int CELL_COUNT = MAP_ROWS * MAP_COLS;
  localparam int AW         = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int RCW        = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;
  localparam int CCW        = (MAP_COLS > 1) ? $clog2(MAP_COLS) : 1;
  localparam int TOTAL_W    = CELL_W + ((CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1);
  localparam int ACC_W      = TOTAL_W + DRAW_W;
  localparam int PROD_W     = CELL_W + DRAW_W;
  localparam int LO_W       = DRAW_W + TOTAL_SPLIT;
  localparam int HI_W       = TOTAL_W - TOTAL_SPLIT;

  // configuration and latched item
  logic [CELL_W-1:0]   floor_value;
  logic [ROW_W-1:0]    item_row;
  logic [COL_W-1:0]    item_col;
  logic [WEIGHT_W-1:0] item_weight;
  logic [DRAW_W-1:0]   item_draw;

  // sweep and scan counters
  logic [AW-1:0]  addr;
  logic [RCW-1:0] row_cnt;
  logic [CCW-1:0] col_cnt;

  // map total and sample target
  logic [TOTAL_W-1:0]      total;
  logic [LO_W-1:0]         p_lo;
  logic [DRAW_W+HI_W-1:0]  p_hi;
  logic [ACC_W-1:0]        target;

  // scan pipeline
  logic             v1, v2, v3;
  logic [RCW-1:0]   r1, r2, r3;
  logic [CCW-1:0]   c1, c2, c3;
  logic [PROD_W-1:0] prod;
  logic [ACC_W-1:0] acc;
  logic             found;
  logic             hit;
  logic [RCW-1:0]   pick_r;
  logic [CCW-1:0]   pick_c;

  // ram hookup
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  // add path
  logic [AW-1:0]     add_addr;
  logic [CELL_W:0]   add_sum;
  logic [CELL_W-1:0] add_sat;
  logic [CELL_W-1:0] add_delta;

  assign add_addr  = AW'(32'(item_row) * MAP_COLS + 32'(item_col));
  assign add_sum   = {1'b0, ram_rdata} + (CELL_W + 1)'(item_weight);
  assign add_sat   = add_sum[CELL_W] ? CELL_MAX : add_sum[CELL_W-1:0];
  assign add_delta = add_sat - ram_rdata;

  // memory port selection
  assign ram_we    = cmd.sweep_wr || cmd.add_wr;
  assign ram_waddr = cmd.add_wr ? add_addr : addr;
  assign ram_wdata = cmd.add_wr ? add_sat : (cmd.sweep_fill ? floor_value : '0);
  assign ram_re    = cmd.add_rd || cmd.scan_rd;
  assign ram_raddr = cmd.add_rd ? add_addr : addr;

  wgrs_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_COUNT)
  ) u_map (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // floor register
  always_ff @(posedge clk) begin
    if (rst) begin
      floor_value <= FLOOR_RESET;
    end else if (cfg_wr) begin
      floor_value <= cfg_data;
    end
  end

  // item capture, draw clamped to one
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_row    <= in_row;
      item_col    <= in_column;
      item_weight <= in_weight;
      item_draw   <= (in_draw > DRAW_ONE) ? DRAW_ONE : in_draw;
    end
  end

  // linear address with row and column tags
  always_ff @(posedge clk) begin
    if (rst || cmd.load_item) begin
      addr    <= '0;
      row_cnt <= '0;
      col_cnt <= '0;
    end else if (cmd.sweep_wr || cmd.scan_rd) begin
      addr <= addr + AW'(1);
      if (col_cnt == CCW'(MAP_COLS - 1)) begin
        col_cnt <= '0;
        row_cnt <= row_cnt + RCW'(1);
      end else begin
        col_cnt <= col_cnt + CCW'(1);
      end
    end
  end

  // running total of all cells
  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
    end else if (cmd.sweep_wr && cmd.sweep_fill) begin
      total <= TOTAL_W'(floor_value) * TOTAL_W'(CELL_COUNT);
    end else if (cmd.add_wr) begin
      total <= total + TOTAL_W'(add_delta);
    end
  end

  // target = draw * total, two partial products then one sum
  always_ff @(posedge clk) begin
    if (cmd.tgt_mul) begin
      p_lo <= LO_W'(item_draw) * LO_W'(total[TOTAL_SPLIT-1:0]);
      p_hi <= (DRAW_W + HI_W)'(item_draw) * (DRAW_W + HI_W)'(total[TOTAL_W-1:TOTAL_SPLIT]);
    end
    if (cmd.scan_start) begin
      target <= ACC_W'(p_lo) + (ACC_W'(p_hi) << TOTAL_SPLIT);
    end
  end

  // scan pipeline valid bits
  always_ff @(posedge clk) begin
    if (rst || cmd.scan_start) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= cmd.scan_rd;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // scan pipeline data: cell times one, then cumulative sum
  always_ff @(posedge clk) begin
    if (cmd.scan_rd) begin
      r1 <= row_cnt;
      c1 <= col_cnt;
    end
    r2   <= r1;
    c2   <= c1;
    prod <= PROD_W'(ram_rdata) * PROD_W'(DRAW_ONE);
    r3   <= r2;
    c3   <= c2;
    if (cmd.scan_start) begin
      acc <= '0;
    end else if (v2) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  assign hit = v3 && !found && (acc >= target);

  // first cell that reaches the target
  always_ff @(posedge clk) begin
    if (rst || cmd.scan_start) begin
      found  <= 1'b0;
      pick_r <= RCW'(MAP_ROWS - 1);
      pick_c <= CCW'(MAP_COLS - 1);
    end else if (hit) begin
      found  <= 1'b1;
      pick_r <= r3;
      pick_c <= c3;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_row    <= ROW_W'(pick_r);
      out_column <= COL_W'(pick_c);
    end
  end

  // status back to the controller
  assign stat.addr_last  = (addr == AW'(CELL_COUNT - 1));
  assign stat.add_ok     = (32'(item_row) < MAP_ROWS) && (32'(item_col) < MAP_COLS);
  assign stat.found      = found;
  assign stat.pipe_empty = !v1 && !v2 && !v3;
  assign stat.out_busy   = out_valid && !out_ready;

`ifndef SYNTH
  // once a pick is made it holds until the next scan starts
  a_pick_holds: assert property (@(posedge clk) disable iff (rst)
    (found && !cmd.scan_start) |=> (found && $stable(pick_r) && $stable(pick_c)))
    else $error("pick changed after match");

  // an add never lowers the total
  a_total_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.add_wr |=> (total >= $past(total)))
    else $error("total decreased on add");

  // the map is not written while a scan reads it
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    (cmd.scan_rd || !stat.pipe_empty) |-> !ram_we)
    else $error("map written during scan");
`endif

endmodule
